// ===== design/command_line_buffer_top_defines.svh =====
// Assertion macros for the command line buffer.
// Used by command_line_buffer_top; expects clk and rst_n in scope.
`ifndef COMMAND_LINE_BUFFER_TOP_DEFINES_SVH
`define COMMAND_LINE_BUFFER_TOP_DEFINES_SVH

// same-cycle implication, held off during reset
`define CLB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define CLB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/clb_pkg.sv =====
// Shared types, codes and constants for the command line buffer.
// No dependencies; used by the front, queue, back and top files and by the bench.
package clb_pkg;

  localparam int LINE_LENGTH_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTER     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKSPACE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE    = 2'd2;

  localparam logic [7:0] ENTER_RST     = 8'd13;
  localparam logic [7:0] BACKSPACE_RST = 8'd8;
  localparam logic [7:0] ESCAPE_RST    = 8'd27;

  // action codes
  localparam logic [1:0] ACT_RX   = 2'd0;
  localparam logic [1:0] ACT_READ = 2'd1;
  localparam logic [1:0] ACT_ACK  = 2'd2;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam int ERR_LEN = 7;

  // what the back end has to send for one word
  typedef enum logic [1:0] {
    KIND_ECHO,
    KIND_CRLF,
    KIND_NONE
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic        ovf;
    logic [7:0]  tx_char;
    logic [7:0]  rdata;
    logic [5:0]  len;
    logic        cmd;
  } job_t;

  // "ERROR" CR LF
  function automatic logic [7:0] err_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'h45;
      3'd1: b = 8'h52;
      3'd2: b = 8'h52;
      3'd3: b = 8'h4F;
      3'd4: b = 8'h52;
      3'd5: b = CHAR_CR;
      3'd6: b = CHAR_LF;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== design/clb_if.sv =====
// Valid/ready channel interfaces for the command line buffer.
// Field widths are fixed; no dependencies.
interface clb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] rx_byte;
  logic [4:0] read_index;

  modport source (output valid, action, rx_byte, read_index, input ready);
  modport sink   (input valid, action, rx_byte, read_index, output ready);
endinterface

interface clb_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic [7:0] read_data;
  logic [5:0] line_length;
  logic       command_ready;
  logic       overflow;
  logic       last;

  modport source (output valid, tx_valid, tx_byte, read_data, line_length,
                  command_ready, overflow, last, input ready);
  modport sink   (input valid, tx_valid, tx_byte, read_data, line_length,
                  command_ready, overflow, last, output ready);
endinterface

// ===== design/clb_front.sv =====
// Front end: takes input words, updates the line store, count and flag,
// and hands one job per word to the queue. Uses clb_pkg and clb_in_if.
module clb_front #(
  parameter int LINE_LENGTH = clb_pkg::LINE_LENGTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  clb_in_if.sink                        in_ch,
  input  logic                          cfg_we,
  input  logic [clb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  output logic                          fr_valid,
  output clb_pkg::job_t                 fr_job,
  input  logic                          q_ready
);

  localparam int CW = $clog2(LINE_LENGTH + 1);
  localparam int AW = $clog2(LINE_LENGTH);
  localparam int IW = (CW > 5) ? CW : 5;

  logic [7:0]    enter_r, bs_r, esc_r;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          pend_r, pend_nxt;
  logic          stage_v_r;
  clb_pkg::job_t job_r, job_nxt;
  logic          rhit_r, rhit_nxt;
  logic [7:0]    rdata_r;
  logic          wr_en;
  logic [7:0]    store_mem [LINE_LENGTH];

  logic          acc;
  logic [IW-1:0] idx_w, fill_w;
  logic [7:0]    c;

  assign in_ch.ready = !stage_v_r || q_ready;
  assign acc    = in_ch.valid && in_ch.ready;
  assign c      = in_ch.rx_byte;
  assign idx_w  = IW'(in_ch.read_index);
  assign fill_w = IW'(fill_r);

  always_comb begin
    fill_nxt = fill_r;
    pend_nxt = pend_r;
    wr_en    = 1'b0;
    rhit_nxt = 1'b0;
    job_nxt  = '0;
    job_nxt.kind    = clb_pkg::KIND_NONE;
    job_nxt.tx_char = c;
    case (in_ch.action)
      clb_pkg::ACT_RX: begin
        job_nxt.kind = (c == enter_r) ? clb_pkg::KIND_CRLF : clb_pkg::KIND_ECHO;
        if (fill_r == CW'(LINE_LENGTH)) begin
          job_nxt.ovf = 1'b1;
          fill_nxt    = '0;
        end else if (c == enter_r) begin
          pend_nxt = 1'b1;
        end else if (c == bs_r) begin
          // entries at or above the count read as zero, so no zero write
          if (fill_r != '0) fill_nxt = fill_r - 1'b1;
        end else if (c == esc_r) begin
          fill_nxt = '0;
        end else begin
          wr_en    = 1'b1;
          fill_nxt = fill_r + 1'b1;
        end
      end
      clb_pkg::ACT_READ: rhit_nxt = idx_w < fill_w;
      clb_pkg::ACT_ACK:  pend_nxt = 1'b0;
      default: ;
    endcase
    job_nxt.len = 6'(fill_nxt);
    job_nxt.cmd = pend_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enter_r   <= clb_pkg::ENTER_RST;
      bs_r      <= clb_pkg::BACKSPACE_RST;
      esc_r     <= clb_pkg::ESCAPE_RST;
      fill_r    <= '0;
      pend_r    <= 1'b0;
      stage_v_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          clb_pkg::CFG_ENTER:     enter_r <= cfg_data;
          clb_pkg::CFG_BACKSPACE: bs_r    <= cfg_data;
          clb_pkg::CFG_ESCAPE:    esc_r   <= cfg_data;
          default: ;
        endcase
      end
      if (acc) begin
        fill_r    <= fill_nxt;
        pend_r    <= pend_nxt;
        stage_v_r <= 1'b1;
      end else if (q_ready) begin
        stage_v_r <= 1'b0;
      end
    end
  end

  // stage payload and line store
  always_ff @(posedge clk) begin
    if (acc) begin
      job_r   <= job_nxt;
      rhit_r  <= rhit_nxt;
      rdata_r <= store_mem[idx_w[AW-1:0]];
      if (wr_en) store_mem[fill_r[AW-1:0]] <= c;
    end
  end

  assign fr_valid = stage_v_r;

  always_comb begin
    fr_job       = job_r;
    fr_job.rdata = rhit_r ? rdata_r : 8'h00;
  end

endmodule

// ===== design/clb_queue.sv =====
// Short job queue between front and back ends.
// Uses clb_pkg for the job type.
module clb_queue #(
  parameter int DEPTH = clb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  input  clb_pkg::job_t push_job,
  output logic          push_ready,
  output logic          pop_valid,
  output clb_pkg::job_t pop_job,
  input  logic          pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  clb_pkg::job_t slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] count_r;
  logic          do_push, do_pop;

  assign push_ready = count_r != NW'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_job    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push)
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_job;
  end

endmodule

// ===== design/clb_back.sv =====
// Back end: expands each job into its result words (echo, error text)
// into an output register. Uses clb_pkg and clb_out_if.
module clb_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  clb_pkg::job_t q_job,
  output logic          q_pop,
  clb_out_if.source     out_ch
);

  logic [3:0] step_r;
  logic [3:0] n_echo, total;
  logic       is_last, load;
  logic       tx_v;
  logic [7:0] tx_b;
  logic       out_v_r;

  assign n_echo  = (q_job.kind == clb_pkg::KIND_CRLF) ? 4'd2 : 4'd1;
  assign total   = n_echo + (q_job.ovf ? 4'(clb_pkg::ERR_LEN) : 4'd0);
  assign is_last = step_r == total - 4'd1;
  assign load    = q_valid && (!out_v_r || out_ch.ready);
  assign q_pop   = load && is_last;

  always_comb begin
    tx_v = 1'b1;
    tx_b = 8'h00;
    if (q_job.kind == clb_pkg::KIND_NONE) begin
      tx_v = 1'b0;
    end else if (step_r < n_echo) begin
      if (q_job.kind == clb_pkg::KIND_CRLF)
        tx_b = (step_r == 4'd0) ? clb_pkg::CHAR_CR : clb_pkg::CHAR_LF;
      else
        tx_b = q_job.tx_char;
    end else begin
      tx_b = clb_pkg::err_byte(3'(step_r - n_echo));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (load) begin
        step_r  <= is_last ? 4'd0 : step_r + 4'd1;
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ch.tx_valid      <= tx_v;
      out_ch.tx_byte       <= tx_b;
      out_ch.read_data     <= q_job.rdata;
      out_ch.line_length   <= q_job.len;
      out_ch.command_ready <= q_job.cmd;
      out_ch.overflow      <= q_job.ovf;
      out_ch.last          <= is_last;
    end
  end

  assign out_ch.valid = out_v_r;

endmodule

// ===== design/command_line_buffer_top.sv =====
// Command line buffer with echo: front end, job queue, back end.
// Depends on clb_pkg, clb_if, clb_front, clb_queue, clb_back and the defines header.
//
// Each input word is a received byte, a read of one stored entry or an
// acknowledge of the command flag. A read, an acknowledge or an ordinary
// byte yields one result word, Enter two (CR LF), and a byte that meets a
// full line 8 or 9 (echo plus "ERROR" CR LF). The back end sends one result
// word per cycle from its output register while the receiver is ready; the
// front end takes a new word every cycle while the queue has room. An accepted
// word passes through the front stage register and a queue slot before its
// first result word reaches the back end's output register. The line store
// needs no clearing pass: entries at or above the fill count read as zero, so
// it is ready straight after reset.
`include "command_line_buffer_top_defines.svh"

module command_line_buffer_top #(
  parameter int LINE_LENGTH = clb_pkg::LINE_LENGTH_DEF,
  parameter int QUEUE_DEPTH = clb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  clb_in_if.sink                        in_ch,
  clb_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [clb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);

  logic          fr_valid, q_ready, q_valid, q_pop;
  clb_pkg::job_t fr_job, q_job;

  clb_front #(.LINE_LENGTH(LINE_LENGTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fr_valid  (fr_valid),
    .fr_job    (fr_job),
    .q_ready   (q_ready)
  );

  clb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_job   (fr_job),
    .push_ready (q_ready),
    .pop_valid  (q_valid),
    .pop_job    (q_job),
    .pop        (q_pop)
  );

  clb_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_job   (q_job),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  // an overflow empties the line and every word of it transmits
  `CLB_ASSERT_IMPL(a_ovf_clears, out_ch.valid && out_ch.overflow, out_ch.line_length == 6'd0 && out_ch.tx_valid, "overflow word with non-empty line or no tx")
  // words without a tx byte are single-word results
  `CLB_ASSERT_IMPL(a_notx_last, out_ch.valid && !out_ch.tx_valid, out_ch.last && out_ch.tx_byte == 8'h00, "silent word not final")
  // read data only on a read result
  `CLB_ASSERT_IMPL(a_rdata_read, out_ch.valid && out_ch.read_data != 8'h00, !out_ch.tx_valid && out_ch.last, "read data on a tx word")
  // an accepted word always lands in the front stage
  `CLB_ASSERT_NEXT(a_front_load, in_ch.valid && in_ch.ready, fr_valid, "accepted word lost in front end")

endmodule

// ===== tb/sv/clb_tb_pkg.sv =====
// Word types and the line buffer scoreboard for the command line buffer bench.
// Depends on clb_pkg for action codes, register indexes and line constants.
package clb_tb_pkg;
  import clb_pkg::*;

  localparam int LINE_LEN = LINE_LENGTH_DEF;
  // action code that the block passes through with no effect
  localparam logic [1:0] ACT_IDLE = 2'd3;
  // "ERROR" CR LF, first character in the top byte
  localparam logic [8*ERR_LEN-1:0] ERR_TEXT = {8'h45, 8'h52, 8'h52, 8'h4F, 8'h52,
                                               CHAR_CR, CHAR_LF};

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
    logic [4:0] read_index;
  } rx_word_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [7:0] read_data;
    logic [5:0] line_length;
    logic       command_ready;
    logic       overflow;
    logic       last;
  } echo_word_t;

  class line_echo_scoreboard;
    logic [7:0]  line_mem [LINE_LEN];
    int unsigned fill;
    bit          cmd_flag;
    logic [7:0]  code_enter;
    logic [7:0]  code_bs;
    logic [7:0]  code_esc;
    echo_word_t  awaited [$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      code_enter = ENTER_RST;
      code_bs    = BACKSPACE_RST;
      code_esc   = ESCAPE_RST;
      cmd_flag   = 1'b0;
      mismatches = 0;
      checked    = 0;
      wipe_line();
    endfunction

    function void wipe_line();
      foreach (line_mem[i]) line_mem[i] = 8'h00;
      fill = 0;
    endfunction

    function void set_code(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
      case (idx)
        CFG_ENTER:     code_enter = val;
        CFG_BACKSPACE: code_bs    = val;
        CFG_ESCAPE:    code_esc   = val;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // works out every result word that one accepted input word causes
    function void note_word(rx_word_t w);
      logic [7:0] txq [$];
      logic       tx_on;
      logic [7:0] rd;
      logic       ovf;
      echo_word_t e;
      txq   = {};
      tx_on = 1'b0;
      rd    = 8'h00;
      ovf   = 1'b0;
      case (w.action)
        ACT_RX: begin
          tx_on = 1'b1;
          if (w.rx_byte == code_enter) begin
            txq.push_back(CHAR_CR);
            txq.push_back(CHAR_LF);
          end else begin
            txq.push_back(w.rx_byte);
          end
          // a full line swallows any byte, terminator or not
          if (fill >= LINE_LEN) begin
            wipe_line();
            ovf = 1'b1;
            for (int k = 0; k < ERR_LEN; k++)
              txq.push_back(ERR_TEXT[8*(ERR_LEN-1-k) +: 8]);
          end else if (w.rx_byte == code_enter) begin
            cmd_flag = 1'b1;
          end else if (w.rx_byte == code_bs) begin
            if (fill > 0) begin
              fill--;
              line_mem[fill] = 8'h00;
            end
          end else if (w.rx_byte == code_esc) begin
            wipe_line();
          end else begin
            line_mem[fill] = w.rx_byte;
            fill++;
          end
        end
        ACT_READ: rd = (w.read_index < LINE_LEN) ? line_mem[w.read_index] : 8'h00;
        ACT_ACK:  cmd_flag = 1'b0;
        default: ;
      endcase
      if (!tx_on) txq.push_back(8'h00);
      foreach (txq[k]) begin
        e.tx_valid      = tx_on;
        e.tx_byte       = txq[k];
        e.read_data     = rd;
        e.line_length   = 6'(fill);
        e.command_ready = cmd_flag;
        e.overflow      = ovf;
        e.last          = (k == txq.size() - 1);
        awaited.push_back(e);
      end
    endfunction

    function string show(echo_word_t w);
      return $sformatf("txv=%0b tx=%02h rd=%02h len=%0d cmd=%0b ovf=%0b last=%0b",
                       w.tx_valid, w.tx_byte, w.read_data, w.line_length,
                       w.command_ready, w.overflow, w.last);
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", what);
    endfunction

    function void check_word(echo_word_t got);
      echo_word_t e;
      string      bad;
      checked++;
      if (awaited.size() == 0) begin
        flag($sformatf("result word %0d with nothing awaited: %s", checked, show(got)));
        return;
      end
      e   = awaited.pop_front();
      bad = "";
      if (got.tx_valid      !== e.tx_valid)      bad = {bad, " tx_valid"};
      if (got.tx_byte       !== e.tx_byte)       bad = {bad, " tx_byte"};
      if (got.read_data     !== e.read_data)     bad = {bad, " read_data"};
      if (got.line_length   !== e.line_length)   bad = {bad, " line_length"};
      if (got.command_ready !== e.command_ready) bad = {bad, " command_ready"};
      if (got.overflow      !== e.overflow)      bad = {bad, " overflow"};
      if (got.last          !== e.last)          bad = {bad, " last"};
      if (bad != "")
        flag($sformatf("result word %0d,%s wrong; expected %s, got %s",
                       checked, bad, show(e), show(got)));
    endfunction
  endclass

endpackage

// ===== tb/sv/tb_command_line_buffer_top.sv =====
// Bench top for command_line_buffer_top: drives input words and register writes,
// checks every result word against clb_tb_pkg's scoreboard. Needs clb_pkg, clb_if.
module tb_command_line_buffer_top;
  import clb_pkg::*;
  import clb_tb_pkg::*;

  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned HOLD_CYCLES = 120;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  clb_in_if  in_ch ();
  clb_out_if out_ch ();

  command_line_buffer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  line_echo_scoreboard sb = new();

  bit          idle_on;
  bit          hold_req;
  bit          want_hold;
  int unsigned phase_items;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_pause();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return 8'h00;
    if (r < 8) return 8'hFF;
    return 8'($urandom_range(1, 254));
  endfunction

  function automatic rx_word_t rx_item(logic [7:0] b);
    return '{ACT_RX, b, 5'($urandom_range(0, 31))};
  endfunction

  function automatic rx_word_t read_item(logic [4:0] idx);
    return '{ACT_READ, 8'($urandom_range(0, 255)), idx};
  endfunction

  function automatic rx_word_t misc_item(logic [1:0] act);
    return '{act, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31))};
  endfunction

  // result side: random stalls, plus one long hold on request
  initial begin
    int unsigned stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HOLD_CYCLES;
      end else if (stall == 0 && idle_on && $urandom_range(0, 99) < 20) begin
        stall = pick_pause();
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_word({out_ch.tx_valid, out_ch.tx_byte, out_ch.read_data, out_ch.line_length,
                     out_ch.command_ready, out_ch.overflow, out_ch.last});
  end

  // ends the run once nothing has moved for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_word(rx_word_t w);
    int unsigned gap;
    gap = pick_pause();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= w.action;
    in_ch.rx_byte    <= w.rx_byte;
    in_ch.read_index <= w.read_index;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_word(w);
    phase_items++;
    if (want_hold && phase_items == 15) hold_req = 1'b1;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_codes(logic [7:0] ent, logic [7:0] bsp, logic [7:0] esc);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ENTER;
    cfg_data  <= ent;
    @(posedge clk);
    cfg_index <= CFG_BACKSPACE;
    cfg_data  <= bsp;
    @(posedge clk);
    cfg_index <= CFG_ESCAPE;
    cfg_data  <= esc;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_code(CFG_ENTER, ent);
    sb.set_code(CFG_BACKSPACE, bsp);
    sb.set_code(CFG_ESCAPE, esc);
  endtask

  task automatic directed_words();
    send_word(read_item(5'd0));
    send_word(read_item(5'd31));
    send_word(rx_item(sb.code_bs));      // backspace with nothing stored
    send_word(rx_item(sb.code_esc));
    send_word(rx_item(sb.code_enter));
    send_word(misc_item(ACT_ACK));
    send_word(rx_item(8'h00));
    send_word(rx_item(8'hFF));
    send_word(rx_item(8'h41));
    send_word(read_item(5'd1));
    send_word(rx_item(sb.code_bs));
    send_word(read_item(5'd2));          // zeroed by the backspace
    send_word(misc_item(ACT_IDLE));
    send_word(rx_item(sb.code_enter));
    send_word(rx_item(sb.code_esc));     // flag survives an escape
    send_word(misc_item(ACT_ACK));
    send_word(rx_item(sb.code_enter));
    // fill the line, then Enter on a full line overflows and leaves the flag alone
    for (int i = 0; i < LINE_LEN; i++) send_word(rx_item(8'h30 + 8'(i)));
    send_word(read_item(5'd31));
    send_word(rx_item(sb.code_enter));
    send_word(read_item(5'd0));
    send_word(misc_item(ACT_ACK));
  endtask

  // one edited command line, mostly well formed
  task automatic run_line();
    int unsigned len;
    int unsigned r;
    int unsigned n_reads;
    len = ($urandom_range(0, 99) < 20) ? $urandom_range(28, 36) : $urandom_range(0, 10);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 5)       send_word(rx_item(sb.code_bs));
      else if (r < 8)  send_word(rx_item(sb.code_esc));
      else if (r < 12) send_word(misc_item(2'($urandom_range(0, 3))));
      else             send_word(rx_item(pick_byte()));
    end
    if ($urandom_range(0, 99) < 80) send_word(rx_item(sb.code_enter));
    n_reads = $urandom_range(0, 3);
    for (int i = 0; i < n_reads; i++) send_word(read_item(5'($urandom_range(0, 31))));
    if ($urandom_range(0, 99) < 70) send_word(misc_item(ACT_ACK));
    if ($urandom_range(0, 99) < 5) send_word(misc_item(ACT_IDLE));
  endtask

  task automatic random_phase(int unsigned n, bit with_hold);
    phase_items = 0;
    want_hold   = with_hold;
    while (phase_items < n) begin
      if ($urandom_range(0, 99) < 85) run_line();
      else send_word(misc_item(2'($urandom_range(0, 3))));
    end
    want_hold = 1'b0;
  endtask

  initial begin
    idle_on          = 1'b0;
    hold_req         = 1'b0;
    want_hold        = 1'b0;
    phase_items      = 0;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_ENTER;
    cfg_data         <= 8'h00;
    in_ch.valid      <= 1'b0;
    in_ch.action     <= ACT_RX;
    in_ch.rx_byte    <= 8'h00;
    in_ch.read_index <= 5'd0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_words();
    drain();

    idle_on = 1'b1;
    write_codes(ENTER_RST, BACKSPACE_RST, ESCAPE_RST);
    random_phase(30, 1'b1);
    drain();
    write_codes(8'h00, 8'hFF, 8'h7F);
    random_phase(25, 1'b0);
    drain();
    // backspace and escape share a code: backspace wins
    write_codes(8'hFF, 8'h00, 8'h00);
    random_phase(25, 1'b0);
    drain();
    // all three coincide: only Enter is seen
    write_codes(8'h41, 8'h41, 8'h41);
    random_phase(20, 1'b0);
    drain();
    idle_on = 1'b0;
    write_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
    random_phase(30, 1'b0);
    drain();
    repeat (8) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/clb_pkg.sv
design/clb_if.sv
design/clb_front.sv
design/clb_queue.sv
design/clb_back.sv
design/command_line_buffer_top.sv
tb/sv/clb_tb_pkg.sv
tb/sv/tb_command_line_buffer_top.sv
